// ----- sv/max_rectangle_binary_matrix_assert.svh -----
// Assertion macros for the max_rectangle_binary_matrix block.
// Used by the port checker; no other dependencies.
`ifndef MAX_RECTANGLE_BINARY_MATRIX_ASSERT_SVH
`define MAX_RECTANGLE_BINARY_MATRIX_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MRBM_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mrbm assertion failed");

// Next-cycle implication, disabled during reset.
`define MRBM_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mrbm assertion failed");

`endif

// ----- sv/mrbm_pkg.sv -----
// Shared sizes, constants and types of the max_rectangle_binary_matrix block.
// No dependencies.
`default_nettype none

package mrbm_pkg;

    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;

    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int CNT_W     = $clog2(MAX_COLS + 1);
    localparam int H_W       = $clog2(MAX_ROWS + 1);
    localparam int STK_DEPTH = MAX_COLS + 1;
    localparam int STK_AW    = $clog2(STK_DEPTH);
    localparam int AREA_W    = 13;
    localparam int CFG_W     = 7;
    localparam int PROD_W    = H_W + CNT_W;
    localparam int RW_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [AREA_W-1:0] AREA_MAX   = '1;
    localparam logic [CFG_W-1:0]  COLS_RESET = 7'd64;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [H_W-1:0]   h;
    } t_stk_entry;

    typedef struct packed {
        logic             valid;
        logic [H_W-1:0]   h;
        logic [CNT_W-1:0] w;
    } t_area_req;

endpackage

`default_nettype wire

// ----- sv/mrbm_hist_mem.sv -----
// Column height memory with per-entry valid bits; unwritten entries read as zero.
// Depends on mrbm_pkg.
`default_nettype none

module mrbm_hist_mem (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_rd_en,
    input  wire logic [mrbm_pkg::COL_W-1:0] i_rd_addr,
    output logic      [mrbm_pkg::H_W-1:0]   o_rd_data,
    input  wire logic                      i_wr_en,
    input  wire logic [mrbm_pkg::COL_W-1:0] i_wr_addr,
    input  wire logic [mrbm_pkg::H_W-1:0]   i_wr_data
);

    logic [mrbm_pkg::H_W-1:0]      mem [mrbm_pkg::MAX_COLS];
    logic [mrbm_pkg::MAX_COLS-1:0] r_valid;
    logic [mrbm_pkg::H_W-1:0]      r_rd_data;
    logic                          r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

`default_nettype wire

// ----- sv/mrbm_stack_mem.sv -----
// Monotonic stack storage of (start column, height) entries.
// Depends on mrbm_pkg.
`default_nettype none

module mrbm_stack_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rd_en,
    input  wire logic [mrbm_pkg::STK_AW-1:0] i_rd_addr,
    output mrbm_pkg::t_stk_entry            o_rd_data,
    input  wire logic                       i_wr_en,
    input  wire logic [mrbm_pkg::STK_AW-1:0] i_wr_addr,
    input  wire mrbm_pkg::t_stk_entry       i_wr_data
);

    mrbm_pkg::t_stk_entry mem [mrbm_pkg::STK_DEPTH];
    mrbm_pkg::t_stk_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- sv/mrbm_area.sv -----
// Area unit: registered height times width product, saturation and running maximum.
// Depends on mrbm_pkg.
`default_nettype none

module mrbm_area (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mrbm_pkg::t_area_req        i_req,
    input  wire logic                       i_clr,
    output logic                            o_busy,
    output logic [mrbm_pkg::AREA_W-1:0]     o_best
);

    localparam int CW = (mrbm_pkg::PROD_W > mrbm_pkg::AREA_W) ?
                        mrbm_pkg::PROD_W : mrbm_pkg::AREA_W;

    logic                          r_v1;
    logic [mrbm_pkg::H_W-1:0]      r_h;
    logic [mrbm_pkg::CNT_W-1:0]    r_w;
    logic                          r_v2;
    logic [mrbm_pkg::PROD_W-1:0]   r_prod;
    logic [mrbm_pkg::AREA_W-1:0]   r_best;
    logic [CW-1:0]                 prod_x;
    logic [mrbm_pkg::AREA_W-1:0]   area_sat;

    always_ff @(posedge i_clk) begin
        r_h    <= i_req.h;
        r_w    <= i_req.w;
        r_prod <= mrbm_pkg::PROD_W'(r_h) * mrbm_pkg::PROD_W'(r_w);
    end

    assign prod_x   = CW'(r_prod);
    assign area_sat = (prod_x > CW'(mrbm_pkg::AREA_MAX)) ? mrbm_pkg::AREA_MAX
                                                         : mrbm_pkg::AREA_W'(prod_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_best <= '0;
        end else begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
            if (i_clr) begin
                r_best <= '0;
            end else if (r_v2 && (area_sat > r_best)) begin
                r_best <= area_sat;
            end
        end
    end

    assign o_busy = r_v1 | r_v2;
    assign o_best = r_best;

endmodule

`default_nettype wire

// ----- sv/max_rectangle_binary_matrix.sv -----
// Largest all-ones rectangle of a streamed binary matrix (histogram and monotonic stack).
// A cell passes through S_HREAD and S_SCAN, and each stack entry popped goes through S_LOAD
// for the stack memory's registered read, unless the stack empties. A row end flushes the
// stack entry by entry; the last cell waits in S_DRAIN for the area unit to drain, and
// its one-cycle result strobe comes in the cycle after. A new cell is taken only when idle.
// Reset (synchronous, active low) clears control state, heights read as zero afterwards.
`default_nettype none

module max_rectangle_binary_matrix (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_cell_req,
    input  wire logic                           i_last_of_matrix,
    output logic                                o_max_area_valid,
    output logic [mrbm_pkg::AREA_W-1:0]         o_max_area,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mrbm_pkg::CFG_W-1:0]     i_cfg_cols_in_use
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HREAD = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    logic [2:0]                       r_state, n_state;
    logic [mrbm_pkg::CFG_W-1:0]       r_cols;
    logic [mrbm_pkg::COL_W-1:0]       r_col, n_col;
    logic                             r_first, n_first;
    logic [mrbm_pkg::CNT_W-1:0]       r_depth, n_depth;
    mrbm_pkg::t_stk_entry             r_top, n_top;
    logic                             r_cell;
    logic                             r_last;
    logic [mrbm_pkg::H_W-1:0]         r_h, n_h;
    logic [mrbm_pkg::COL_W-1:0]       r_start, n_start;
    logic                             r_flush, n_flush;
    logic                             r_out_v, n_out_v;
    logic [mrbm_pkg::AREA_W-1:0]      r_out, n_out;

    logic                             accept;
    logic [mrbm_pkg::H_W-1:0]         hist_rd;
    logic                             hist_we;
    logic [mrbm_pkg::H_W-1:0]         h_new;
    logic                             stk_re, stk_we;
    logic [mrbm_pkg::STK_AW-1:0]      stk_raddr, stk_waddr;
    mrbm_pkg::t_stk_entry             stk_rd, stk_wd;
    mrbm_pkg::t_area_req              area_req;
    logic                             area_clr;
    logic                             area_busy;
    logic [mrbm_pkg::AREA_W-1:0]      best;
    logic [mrbm_pkg::RW_W-1:0]        row_w;
    logic                             row_end;
    logic                             pop;
    logic [mrbm_pkg::CNT_W-1:0]       depth_dec;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Effective row width: zero acts as one, anything above the array size is clipped.
    always_comb begin
        if (r_cols == '0) begin
            row_w = mrbm_pkg::RW_W'(1);
        end else if (mrbm_pkg::RW_W'(r_cols) > mrbm_pkg::RW_W'(mrbm_pkg::MAX_COLS)) begin
            row_w = mrbm_pkg::RW_W'(mrbm_pkg::MAX_COLS);
        end else begin
            row_w = mrbm_pkg::RW_W'(r_cols);
        end
    end

    assign row_end = r_last || ((mrbm_pkg::RW_W'(r_col) + mrbm_pkg::RW_W'(1)) >= row_w);

    always_comb begin
        if (!r_cell) begin
            h_new = '0;
        end else if (r_first) begin
            h_new = mrbm_pkg::H_W'(1);
        end else if (hist_rd >= mrbm_pkg::H_W'(mrbm_pkg::MAX_ROWS)) begin
            h_new = mrbm_pkg::H_W'(mrbm_pkg::MAX_ROWS);
        end else begin
            h_new = hist_rd + mrbm_pkg::H_W'(1);
        end
    end

    assign hist_we = (r_state == S_HREAD);

    mrbm_hist_mem u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (hist_rd),
        .i_wr_en   (hist_we),
        .i_wr_addr (r_col),
        .i_wr_data (h_new)
    );

    mrbm_stack_mem u_stack (
        .i_clk     (i_clk),
        .i_rd_en   (stk_re),
        .i_rd_addr (stk_raddr),
        .o_rd_data (stk_rd),
        .i_wr_en   (stk_we),
        .i_wr_addr (stk_waddr),
        .i_wr_data (stk_wd)
    );

    mrbm_area u_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (area_req),
        .i_clr   (area_clr),
        .o_busy  (area_busy),
        .o_best  (best)
    );

    // During a flush every entry pops; otherwise entries not lower than the new bar pop.
    assign pop       = (r_state == S_SCAN) && (r_depth != '0) && (r_flush || (r_top.h >= r_h));
    assign depth_dec = r_depth - mrbm_pkg::CNT_W'(1);

    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_first   = r_first;
        n_depth   = r_depth;
        n_top     = r_top;
        n_h       = r_h;
        n_start   = r_start;
        n_flush   = r_flush;
        n_out_v   = 1'b0;
        n_out     = r_out;
        stk_re    = 1'b0;
        stk_raddr = mrbm_pkg::STK_AW'(depth_dec - mrbm_pkg::CNT_W'(1));
        stk_we    = 1'b0;
        stk_waddr = mrbm_pkg::STK_AW'(r_depth);
        stk_wd.col = r_start;
        stk_wd.h   = r_h;
        area_req.valid = 1'b0;
        area_req.h     = r_top.h;
        area_req.w     = r_flush ?
            (mrbm_pkg::CNT_W'(r_col) + mrbm_pkg::CNT_W'(1) - mrbm_pkg::CNT_W'(r_top.col)) :
            (mrbm_pkg::CNT_W'(r_col) - mrbm_pkg::CNT_W'(r_top.col));
        area_clr  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_HREAD;
                end
            end
            S_HREAD: begin
                n_h     = h_new;
                n_start = r_col;
                n_flush = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (pop) begin
                    area_req.valid = 1'b1;
                    n_start = r_top.col;
                    n_depth = depth_dec;
                    if (depth_dec != '0) begin
                        stk_re  = 1'b1;
                        n_state = S_LOAD;
                    end
                end else if (!r_flush) begin
                    if (r_depth <= mrbm_pkg::CNT_W'(mrbm_pkg::MAX_COLS)) begin
                        stk_we    = 1'b1;
                        n_top.col = r_start;
                        n_top.h   = r_h;
                        n_depth   = r_depth + mrbm_pkg::CNT_W'(1);
                    end
                    if (row_end) begin
                        n_flush = 1'b1;
                    end else begin
                        n_col   = r_col + mrbm_pkg::COL_W'(1);
                        n_state = S_IDLE;
                    end
                end else begin
                    n_col   = '0;
                    n_first = 1'b0;
                    n_state = r_last ? S_DRAIN : S_IDLE;
                end
            end
            S_LOAD: begin
                n_top   = stk_rd;
                n_state = S_SCAN;
            end
            S_DRAIN: begin
                if (!area_busy) begin
                    n_out    = best;
                    n_out_v  = 1'b1;
                    area_clr = 1'b1;
                    n_first  = 1'b1;
                    n_depth  = '0;
                    n_col    = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cols  <= mrbm_pkg::COLS_RESET;
            r_col   <= '0;
            r_first <= 1'b1;
            r_depth <= '0;
            r_flush <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cols <= i_cfg_cols_in_use;
            end
            r_col   <= n_col;
            r_first <= n_first;
            r_depth <= n_depth;
            r_flush <= n_flush;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cell <= i_cell_req;
            r_last <= i_last_of_matrix;
        end
        r_top   <= n_top;
        r_h     <= n_h;
        r_start <= n_start;
        r_out   <= n_out;
    end

    assign o_max_area_valid = r_out_v;
    assign o_max_area       = r_out;

endmodule

`default_nettype wire

// ----- sv/mrbm_checker.sv -----
// Port-level checker for max_rectangle_binary_matrix, bound to the top level.
// Depends on mrbm_pkg and max_rectangle_binary_matrix_assert.svh.
`default_nettype none

`include "max_rectangle_binary_matrix_assert.svh"

module mrbm_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_start,
    input wire logic                       i_busy,
    input wire logic                       i_max_area_valid,
    input wire logic [mrbm_pkg::AREA_W-1:0] i_max_area
);

    // An accepted request keeps the block busy in the next cycle.
    `MRBM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy)
    // A result only comes out at the end of a busy period.
    `MRBM_ASSERT_IMP(a_result_after_busy, i_clk, i_rst_n, i_max_area_valid, $past(i_busy))
    // The result strobe never lasts more than one cycle.
    `MRBM_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, i_max_area_valid, !i_max_area_valid)
    // No rectangle exceeds the full matrix area.
    `MRBM_ASSERT_IMP(a_area_bound, i_clk, i_rst_n, i_max_area_valid, i_max_area <= 13'd4096)

endmodule

bind max_rectangle_binary_matrix mrbm_checker u_mrbm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_start          (start),
    .i_busy           (busy),
    .i_max_area_valid (o_max_area_valid),
    .i_max_area       (o_max_area)
);

`default_nettype wire

// ----- tb/sv/mrbm_area_checker.sv -----
// Checker for the max_rectangle_binary_matrix block: it watches the cell, result and
// configuration channels, predicts each matrix area and compares it. Depends on mrbm_pkg.
module mrbm_area_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic                        i_busy,
    input  wire logic                        i_cell_req,
    input  wire logic                        i_last_of_matrix,
    input  wire logic                        i_max_area_valid,
    input  wire logic [mrbm_pkg::AREA_W-1:0] i_max_area,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_ready,
    input  wire logic [mrbm_pkg::CFG_W-1:0]  i_cfg_cols_in_use,
    output int                               o_error_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [mrbm_pkg::H_W-1:0]    col_height [mrbm_pkg::MAX_COLS];
    logic [mrbm_pkg::CNT_W-1:0]  bar_start  [mrbm_pkg::STK_DEPTH];
    logic [mrbm_pkg::H_W-1:0]    bar_height [mrbm_pkg::STK_DEPTH];
    logic [mrbm_pkg::CNT_W-1:0]  bar_count;
    logic [mrbm_pkg::COL_W-1:0]  col_pos;
    logic                        first_row;
    logic [mrbm_pkg::AREA_W-1:0] best_area;
    logic [mrbm_pkg::CFG_W-1:0]  cols_cfg;
    logic [mrbm_pkg::AREA_W-1:0] areas_due [$];
    logic [mrbm_pkg::AREA_W-1:0] want;
    int                          error_total;
    int                          k;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
        error_total   = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        error_total++;
    endtask

    task automatic note_rect(input int height, input int span);
        int a;
        a = height * span;
        if (a > int'(mrbm_pkg::AREA_MAX)) a = int'(mrbm_pkg::AREA_MAX);
        if (a > int'(best_area)) best_area = mrbm_pkg::AREA_W'(a);
    endtask

    // Folds one accepted cell into the histogram and the bar stack.
    task automatic scan_cell(input logic cell_bit, input logic last);
        int col, h, start_col, width, top;
        col = int'(col_pos);
        if (col >= mrbm_pkg::MAX_COLS) col = mrbm_pkg::MAX_COLS - 1;
        if (cell_bit == 1'b0) begin
            h = 0;
        end else if (first_row) begin
            h = 1;
        end else begin
            h = int'(col_height[col]) + 1;
            if (h > mrbm_pkg::MAX_ROWS) h = mrbm_pkg::MAX_ROWS;
        end
        col_height[col] = mrbm_pkg::H_W'(h);

        // Bars at least as tall as the new one end just before this column.
        start_col = col;
        top = int'(bar_count);
        while (top > 0 && int'(bar_height[top-1]) >= h) begin
            top--;
            start_col = int'(bar_start[top]);
            note_rect(int'(bar_height[top]), col - start_col);
        end
        if (top <= mrbm_pkg::MAX_COLS) begin
            bar_start[top]  = mrbm_pkg::CNT_W'(start_col);
            bar_height[top] = mrbm_pkg::H_W'(h);
            top++;
        end

        width = int'(cols_cfg);
        if (width < 1) width = 1;
        if (width > mrbm_pkg::MAX_COLS) width = mrbm_pkg::MAX_COLS;
        if (last || col + 1 >= width) begin
            while (top > 0) begin
                top--;
                note_rect(int'(bar_height[top]), col + 1 - int'(bar_start[top]));
            end
            col_pos   = '0;
            first_row = 1'b0;
        end else begin
            col_pos = mrbm_pkg::COL_W'(col + 1);
        end
        bar_count = mrbm_pkg::CNT_W'(top);

        if (last) begin
            areas_due.push_back(best_area);
            best_area = '0;
            first_row = 1'b1;
            bar_count = '0;
            col_pos   = '0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (k = 0; k < mrbm_pkg::MAX_COLS; k++) col_height[k] = '0;
            bar_count = '0;
            col_pos   = '0;
            first_row = 1'b1;
            best_area = '0;
            cols_cfg  = mrbm_pkg::COLS_RESET;
            areas_due.delete();
        end else begin
            // A result at this edge belongs to an earlier request than one accepted now.
            if (i_max_area_valid) begin
                if (areas_due.size() == 0) begin
                    report_mismatch($sformatf("area %0d with no matrix pending", i_max_area));
                end else begin
                    want = areas_due.pop_front();
                    if (i_max_area !== want)
                        report_mismatch($sformatf("max_area %0d, expected %0d",
                                                  i_max_area, want));
                end
            end
            if (i_cfg_valid && i_cfg_ready) cols_cfg = i_cfg_cols_in_use;
            if (i_start && !i_busy) scan_cell(i_cell_req, i_last_of_matrix);
        end
        o_pending     <= areas_due.size();
        o_error_count <= error_total;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the max_rectangle_binary_matrix testbench: clock, reset, cell and width stimulus,
// and the verdict. Depends on mrbm_pkg, the block and mrbm_area_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 400;
    localparam int ITEM_TARGET   = 1800;

    logic                        i_clk;
    logic                        i_rst_n           = 1'b0;
    logic                        start             = 1'b0;
    logic                        i_cell_req        = 1'b0;
    logic                        i_last_of_matrix  = 1'b0;
    logic                        i_cfg_valid       = 1'b0;
    logic [mrbm_pkg::CFG_W-1:0]  i_cfg_cols_in_use = '0;
    logic                        busy;
    logic                        o_max_area_valid;
    logic [mrbm_pkg::AREA_W-1:0] o_max_area;
    logic                        o_cfg_ready;
    int                          error_count;
    int                          pending;
    int                          items_sent        = 0;
    bit                          no_idle           = 1'b0;

    max_rectangle_binary_matrix i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cell_req        (i_cell_req),
        .i_last_of_matrix  (i_last_of_matrix),
        .o_max_area_valid  (o_max_area_valid),
        .o_max_area        (o_max_area),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_cols_in_use (i_cfg_cols_in_use)
    );

    mrbm_area_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_cell_req        (i_cell_req),
        .i_last_of_matrix  (i_last_of_matrix),
        .i_max_area_valid  (o_max_area_valid),
        .i_max_area        (o_max_area),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_cols_in_use (i_cfg_cols_in_use),
        .o_error_count     (error_count),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(30, 100);
    endfunction

    // Returns at the edge that accepts the request; start stays high until the caller's
    // next assignment in the same time step.
    task automatic send_cell(input logic cell_bit, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_cell_req       <= cell_bit;
        i_last_of_matrix <= last;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // Sends n cells, bit 0 first; the final one closes the matrix when end_matrix is set.
    task automatic send_seq(input logic [31:0] bits, input int n, input bit end_matrix);
        int i;
        for (i = 0; i < n; i++) send_cell(bits[i], end_matrix && (i == n - 1));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // A cell that ends no matrix may still be in flight, so the block gets time to settle.
    task automatic write_cols(input logic [mrbm_pkg::CFG_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_cols_in_use <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int                         r, width, rows, density, style, cut, n_mat, rr, cc;
        logic [mrbm_pkg::CFG_W-1:0] cfg;
        logic                       cell_bit, last;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short final row at the reset width.
        send_seq(32'b111, 3, 1'b1);
        // Three by three matrix, then one whose first row ignores the old heights.
        write_cols(7'd3);
        send_seq(32'b110111011, 9, 1'b1);
        send_seq(32'b111, 3, 1'b1);
        // A width of zero acts as one column, an oversized width as the maximum.
        write_cols(7'd0);
        send_seq(32'b1011, 4, 1'b1);
        write_cols(7'd127);
        send_seq(32'b101, 3, 1'b1);
        // Narrowing the row while one is half done ends that row on the next cell.
        write_cols(7'd5);
        send_seq(32'b11, 2, 1'b0);
        write_cols(7'd2);
        send_seq(32'b111, 3, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 8)       cfg = 7'd0;
            else if (r < 16) cfg = 7'd1;
            else if (r < 55) cfg = mrbm_pkg::CFG_W'($urandom_range(2, 8));
            else if (r < 70) cfg = mrbm_pkg::CFG_W'($urandom_range(9, 20));
            else if (r < 76) cfg = 7'd64;
            else if (r < 80) cfg = 7'd127;
            else if (r < 85) cfg = mrbm_pkg::CFG_W'($urandom_range(65, 126));
            else             cfg = mrbm_pkg::CFG_W'($urandom_range(21, 63));
            write_cols(cfg);
            width = (cfg == 0) ? 1 : (cfg > mrbm_pkg::MAX_COLS) ? mrbm_pkg::MAX_COLS : int'(cfg);
            no_idle = ($urandom_range(0, 3) == 0);

            n_mat = $urandom_range(1, 4);
            repeat (n_mat) begin
                if (width <= 8)       rows = $urandom_range(1, 8);
                else if (width <= 20) rows = $urandom_range(1, 3);
                else                  rows = $urandom_range(1, 2);
                case ($urandom_range(0, 4))
                    0:       density = 0;
                    1:       density = 30;
                    2:       density = 60;
                    3:       density = 85;
                    default: density = 100;
                endcase
                // Tall single columns drive the heights into saturation.
                if (width == 1 && $urandom_range(0, 3) == 0) begin
                    rows    = $urandom_range(60, 80);
                    density = 100;
                end
                style = $urandom_range(0, 9);
                cut = (style == 8) ? $urandom_range(0, width - 1) : width - 1;
                for (rr = 0; rr < rows; rr++) begin
                    for (cc = 0; cc < width; cc++) begin
                        if (rr == rows - 1 && cc > cut) break;
                        cell_bit = ($urandom_range(0, 99) < density);
                        last = (rr == rows - 1 && cc == cut);
                        if (style == 9) last = ($urandom_range(0, 29) == 0);
                        send_cell(cell_bit, last);
                    end
                end
            end
            // Leave a matrix open so the next width change lands mid-row.
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, width)) send_cell(1'($urandom_range(0, 1)), 1'b0);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
